// ===== rtl/core/pdoa_aoa_pkg.sv =====
// Package for the phase-difference angle-of-arrival unit.
// Shared constants, register index codes and the CORDIC arctangent table.
// No dependencies.
package pdoa_aoa_pkg;

  // Default values of the top-level parameters
  localparam int unsigned COUNTS_PER_HALF_TURN = 4096;
  localparam int unsigned CORDIC_STAGES        = 16;
  localparam int unsigned ANGLE_BITS           = 16;

  // Fixed field widths
  localparam int unsigned PHASE_BITS     = 16;
  localparam int unsigned IN_DATA_BITS   = 2 * PHASE_BITS;
  localparam int unsigned OUT_BITS       = 16;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned OFFSET_BITS    = 9;

  // Degree offset: angle = off * 2^ANGLE_BITS / 360, done as off * 2^(AB+1) / 720
  localparam int unsigned OFFSET_DIVISOR = 720;

  // Headroom of the CORDIC x/y words above ANGLE_BITS
  localparam int unsigned CORDIC_GUARD_BITS = 35;

  // sqrt(3) in Q2.30, truncated
  localparam int unsigned          SQRT3_FRAC_BITS = 30;
  localparam logic signed [31:0]   SQRT3_Q30       = 32'sd1859775393;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BIAS_21 = 2'd0,
    CFG_BIAS_31 = 2'd1,
    CFG_OFFSET  = 2'd2
  } cfg_index_e;

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Arctangent step rounded to ab bits, ties up
  function automatic logic [31:0] atan_step(input logic [4:0] idx, input int unsigned ab);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - ab));
    return 32'(t >> (32 - ab));
  endfunction

endpackage

// ===== rtl/core/pdoa_to_angle_of_arrival_unit.sv =====
// Top level of the angle-of-arrival unit: config block, front end, CORDIC
// chain and output register. Uses pdoa_aoa_pkg and the pdoa_aoa_* modules.
//
// Turns two antenna phase differences (binary angles, 32768 = 180 deg) into
// an angle of arrival: each phase is negated, its bias removed and wrapped,
// y = sqrt3*(c13-c12) and x = c12+c13 are formed, atan2(y,x) comes from a
// CordicStages-deep vectoring CORDIC (zero vector gives 0), then the degree
// offset is added and the result rounded to a 16-bit binary angle where
// -32768 means +180 deg. The pipeline takes one beat per cycle while no
// stall or config conversion holds it; each beat passes through the input
// register, correction, sqrt3 multiply, quadrant pre-rotation, one
// stage per CORDIC iteration and the output register. Every stage has its
// own valid and can fill while downstream is stalled, so input beats keep
// flowing into empty stages while a result waits on m_axis_tready.
// A config write to a known index is turned into a binary angle in two
// steps (short products, then a reciprocal multiply); cfg_ready_o and
// s_axis_tready drop in the cycle after the write beat. Write config
// only while the pipeline is empty. Writes to an unknown index are taken
// and dropped.
module pdoa_to_angle_of_arrival_unit #(
  parameter int unsigned CountsPerHalfTurn = pdoa_aoa_pkg::COUNTS_PER_HALF_TURN,
  parameter int unsigned CordicStages      = pdoa_aoa_pkg::CORDIC_STAGES,
  parameter int unsigned AngleBits         = pdoa_aoa_pkg::ANGLE_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // [15:0] phase_ant2_ant1, [31:16] phase_ant3_ant1
  input  logic [pdoa_aoa_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [15:0] arrival_angle
  output logic [pdoa_aoa_pkg::OUT_BITS-1:0]       m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [pdoa_aoa_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [pdoa_aoa_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import pdoa_aoa_pkg::*;

  localparam int unsigned CordicBits = AngleBits + CORDIC_GUARD_BITS;
  localparam int unsigned RoundBits  = AngleBits + OUT_BITS + 1;
  localparam logic [RoundBits-1:0] OutRound = RoundBits'(1) << AngleBits;

  // converted config, binary angles mod 2^AngleBits
  logic [AngleBits-1:0] bias21, bias31, offset;

  pdoa_aoa_cfg #(
    .AngleBits         (AngleBits),
    .CountsPerHalfTurn (CountsPerHalfTurn)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .bias21_o    (bias21),
    .bias31_o    (bias31),
    .offset_o    (offset)
  );

  // inputs held off while a conversion runs
  logic front_ready;
  assign s_axis_tready = front_ready && cfg_ready_o;

  // CORDIC chain links; link k feeds stage k
  logic                         vld [CordicStages+1];
  logic                         rdy [CordicStages+1];
  logic signed [CordicBits-1:0] cx  [CordicStages+1];
  logic signed [CordicBits-1:0] cy  [CordicStages+1];
  logic [AngleBits-1:0]         cz  [CordicStages+1];
  logic                         czr [CordicStages+1];

  pdoa_aoa_front #(
    .AngleBits  (AngleBits),
    .CordicBits (CordicBits)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && cfg_ready_o),
    .in_ready_o  (front_ready),
    .phase21_i   (s_axis_tdata[PHASE_BITS-1:0]),
    .phase31_i   (s_axis_tdata[IN_DATA_BITS-1:PHASE_BITS]),
    .bias21_i    (bias21),
    .bias31_i    (bias31),
    .out_valid_o (vld[0]),
    .out_ready_i (rdy[0]),
    .x_o         (cx[0]),
    .y_o         (cy[0]),
    .z_o         (cz[0]),
    .zero_o      (czr[0])
  );

  for (genvar g = 0; g < CordicStages; g++) begin : g_cordic
    pdoa_aoa_cordic_stage #(
      .AngleBits  (AngleBits),
      .CordicBits (CordicBits),
      .Index      (g)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (vld[g]),
      .in_ready_o  (rdy[g]),
      .x_i         (cx[g]),
      .y_i         (cy[g]),
      .z_i         (cz[g]),
      .zero_i      (czr[g]),
      .out_valid_o (vld[g+1]),
      .out_ready_i (rdy[g+1]),
      .x_o         (cx[g+1]),
      .y_o         (cy[g+1]),
      .z_o         (cz[g+1]),
      .zero_o      (czr[g+1])
    );
  end

  // output stage: zero-vector override, offset, round to 16 bits
  logic                  out_valid_q;
  logic [OUT_BITS-1:0]   out_data_q;
  logic [AngleBits-1:0]  angle_sum;
  logic [RoundBits-1:0]  angle_rnd;
  logic                  out_ready;

  assign out_ready = !out_valid_q || m_axis_tready;
  assign rdy[CordicStages] = out_ready;

  // cx/cy of the last link carry the residual vector only; angle is all we need
  assign angle_sum = (czr[CordicStages] ? '0 : cz[CordicStages]) + offset;
  assign angle_rnd = {angle_sum, {(OUT_BITS + 1){1'b0}}} + OutRound;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= vld[CordicStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && vld[CordicStages]) begin
      out_data_q <= angle_rnd[RoundBits-1:AngleBits+1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/core/pdoa_aoa_cfg.sv =====
// Configuration registers of the angle-of-arrival unit with a two-step
// converter from bias counts and degrees to binary angles. Uses pdoa_aoa_pkg.
module pdoa_aoa_cfg #(
  parameter int unsigned AngleBits         = pdoa_aoa_pkg::ANGLE_BITS,
  parameter int unsigned CountsPerHalfTurn = pdoa_aoa_pkg::COUNTS_PER_HALF_TURN
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [pdoa_aoa_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [pdoa_aoa_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output logic [AngleBits-1:0]                     bias21_o,
  output logic [AngleBits-1:0]                     bias31_o,
  output logic [AngleBits-1:0]                     offset_o
);
  import pdoa_aoa_pkg::*;

  // floor(v * 2^K + rnd, D) mod 2^AB with 2^K = D * Q0 + R0: the Q0 part is a
  // short product, the R0 part leaves a small positive numerator (lifted by
  // a whole number of divisors) that a reciprocal multiply divides exactly.
  // Bias data is split into a signed high byte and an unsigned low byte so
  // that numerator stays below 2^9 divisors, as does the 9-bit offset's.
  localparam int unsigned SplitBits = 8;
  localparam int unsigned SpanBits  = 9;

  localparam longint BiasDiv   = longint'(2 * CountsPerHalfTurn);
  localparam longint BiasRnd   = longint'(CountsPerHalfTurn);
  localparam longint BiasTurn  = longint'(1) << AngleBits;
  localparam longint BiasQ0    = BiasTurn / BiasDiv;
  localparam longint BiasR0    = BiasTurn % BiasDiv;
  localparam longint BiasQ1    = (BiasR0 << SplitBits) / BiasDiv;
  localparam longint BiasR1    = (BiasR0 << SplitBits) % BiasDiv;
  localparam longint BiasLift  = 128;
  localparam int unsigned BiasDivBits = $clog2(BiasDiv);
  localparam int unsigned BiasShift   = SpanBits + 2 * BiasDivBits;
  localparam longint BiasMul   = ((longint'(1) << BiasShift) + BiasDiv - 1) / BiasDiv;

  localparam longint OffDiv    = longint'(OFFSET_DIVISOR);
  localparam longint OffRnd    = OffDiv / 2;
  localparam longint OffTurn   = longint'(1) << (AngleBits + 1);
  localparam longint OffQ0     = OffTurn / OffDiv;
  localparam longint OffR0     = OffTurn % OffDiv;
  localparam longint OffLift   = 256;
  localparam int unsigned OffDivBits = $clog2(OffDiv);
  localparam int unsigned OffShift   = SpanBits + 2 * OffDivBits;
  localparam longint OffMul    = ((longint'(1) << OffShift) + OffDiv - 1) / OffDiv;

  localparam int unsigned DivBits  = (BiasDivBits > OffDivBits) ? BiasDivBits : OffDivBits;
  localparam int unsigned NumBits  = DivBits + SpanBits;
  localparam int unsigned MulBits  = DivBits + SpanBits + 2;
  localparam int unsigned WideBits = NumBits + 2;
  localparam int unsigned ProdBits = NumBits + MulBits;

  localparam logic [AngleBits-1:0]       BiasQ0W   = AngleBits'(BiasQ0);
  localparam logic [AngleBits-1:0]       BiasQ1W   = AngleBits'(BiasQ1);
  localparam logic [AngleBits-1:0]       OffQ0W    = AngleBits'(OffQ0);
  localparam logic signed [WideBits-1:0] BiasR0S   = WideBits'(BiasR0);
  localparam logic signed [WideBits-1:0] BiasR1S   = WideBits'(BiasR1);
  localparam logic signed [WideBits-1:0] BiasAddS  = WideBits'(BiasRnd + BiasLift * BiasDiv);
  localparam logic signed [WideBits-1:0] OffR0S    = WideBits'(OffR0);
  localparam logic signed [WideBits-1:0] OffAddS   = WideBits'(OffRnd + OffLift * OffDiv);
  localparam logic [MulBits-1:0]         BiasMulW  = MulBits'(BiasMul);
  localparam logic [MulBits-1:0]         OffMulW   = MulBits'(OffMul);
  localparam logic [AngleBits-1:0]       BiasLiftW = AngleBits'(BiasLift);
  localparam logic [AngleBits-1:0]       OffLiftW  = AngleBits'(OffLift);

  logic                        busy_q, busy_d;
  logic [NumBits-1:0]          num_q, num_d;
  logic [AngleBits-1:0]        base_q, base_d;
  cfg_index_e                  dst_q, dst_d;
  logic [AngleBits-1:0]        bias21_q, bias21_d;
  logic [AngleBits-1:0]        bias31_q, bias31_d;
  logic [AngleBits-1:0]        offset_q, offset_d;

  logic signed [WideBits-1:0]  hi_s, lo_s, off_s, bias_num, off_num;
  logic [AngleBits-1:0]        val_a, hi_a, off_a, bias_base, off_base;
  logic [MulBits-1:0]          mul_sel;
  logic [ProdBits-1:0]         prod;
  logic [AngleBits-1:0]        quot;
  logic [AngleBits-1:0]        result;
  logic                        start;
  logic                        known_idx;

  assign cfg_ready_o = !busy_q;
  assign known_idx   = (cfg_index_i == CFG_BIAS_21) || (cfg_index_i == CFG_BIAS_31) ||
                       (cfg_index_i == CFG_OFFSET);
  assign start       = cfg_valid_i && cfg_ready_o && known_idx;

  // step 1: short products mod 2^AB and the small lifted numerator
  assign hi_s  = WideBits'($signed(cfg_data_i[CFG_DATA_BITS-1:SplitBits]));
  assign lo_s  = WideBits'(cfg_data_i[SplitBits-1:0]);
  assign off_s = WideBits'($signed(cfg_data_i[OFFSET_BITS-1:0]));
  assign val_a = AngleBits'($signed(cfg_data_i));
  assign hi_a  = AngleBits'($signed(cfg_data_i[CFG_DATA_BITS-1:SplitBits]));
  assign off_a = AngleBits'($signed(cfg_data_i[OFFSET_BITS-1:0]));

  assign bias_num  = hi_s * BiasR1S + lo_s * BiasR0S + BiasAddS;
  assign off_num   = off_s * OffR0S + OffAddS;
  assign bias_base = val_a * BiasQ0W + hi_a * BiasQ1W;
  assign off_base  = off_a * OffQ0W;

  // step 2: exact quotient of the small numerator by reciprocal multiply
  assign mul_sel = (dst_q == CFG_OFFSET) ? OffMulW : BiasMulW;
  assign prod    = ProdBits'(num_q) * ProdBits'(mul_sel);
  assign quot    = (dst_q == CFG_OFFSET) ? (AngleBits'(prod >> OffShift) - OffLiftW) :
                                           (AngleBits'(prod >> BiasShift) - BiasLiftW);
  assign result  = base_q + quot;

  always_comb begin
    busy_d   = busy_q;
    num_d    = num_q;
    base_d   = base_q;
    dst_d    = dst_q;
    bias21_d = bias21_q;
    bias31_d = bias31_q;
    offset_d = offset_q;
    if (start) begin
      busy_d = 1'b1;
      dst_d  = cfg_index_e'(cfg_index_i);
      if (cfg_index_i == CFG_OFFSET) begin
        num_d  = off_num[NumBits-1:0];
        base_d = off_base;
      end else begin
        num_d  = bias_num[NumBits-1:0];
        base_d = bias_base;
      end
    end else if (busy_q) begin
      busy_d = 1'b0;
      unique case (dst_q)
        CFG_BIAS_21: bias21_d = result;
        CFG_BIAS_31: bias31_d = result;
        CFG_OFFSET:  offset_d = result;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      dst_q    <= CFG_BIAS_21;
      bias21_q <= '0;
      bias31_q <= '0;
      offset_q <= '0;
    end else begin
      busy_q   <= busy_d;
      dst_q    <= dst_d;
      bias21_q <= bias21_d;
      bias31_q <= bias31_d;
      offset_q <= offset_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    base_q <= base_d;
  end

  assign bias21_o = bias21_q;
  assign bias31_o = bias31_q;
  assign offset_o = offset_q;

endmodule

// ===== rtl/core/pdoa_aoa_front.sv =====
// Front end: input register, phase correction and wrap, sqrt3 scaling and
// the quadrant pre-rotation, as four pipeline stages. Uses pdoa_aoa_pkg.
module pdoa_aoa_front #(
  parameter int unsigned AngleBits  = pdoa_aoa_pkg::ANGLE_BITS,
  parameter int unsigned CordicBits = pdoa_aoa_pkg::ANGLE_BITS +
                                      pdoa_aoa_pkg::CORDIC_GUARD_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [pdoa_aoa_pkg::PHASE_BITS-1:0]   phase21_i,
  input  logic [pdoa_aoa_pkg::PHASE_BITS-1:0]   phase31_i,
  input  logic [AngleBits-1:0]                  bias21_i,
  input  logic [AngleBits-1:0]                  bias31_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [CordicBits-1:0]          x_o,
  output logic signed [CordicBits-1:0]          y_o,
  output logic [AngleBits-1:0]                  z_o,
  output logic                                  zero_o
);
  import pdoa_aoa_pkg::*;

  localparam int unsigned ScaleBits = AngleBits + PHASE_BITS + 1;
  localparam int unsigned SumBits   = AngleBits + 2;
  localparam int unsigned ProdBits  = SumBits + 32;
  localparam int unsigned XBits     = SumBits + SQRT3_FRAC_BITS;
  localparam logic [ScaleBits-1:0] InRound = ScaleBits'(1) << PHASE_BITS;
  localparam logic [AngleBits-1:0] Quarter = AngleBits'(1) << (AngleBits - 2);

  // stage valids and ready chain
  logic v0_q, v1_q, v2_q, v3_q;
  logic r0, r1, r2, r3;

  assign r3 = !v3_q || out_ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign r0 = !v0_q || r1;
  assign in_ready_o = r0;

  // stage 0: raw phases
  logic [PHASE_BITS-1:0] p21_q, p31_q;

  // stage 1: correct, wrap to (-half, half], difference and sum
  logic [ScaleBits-1:0]      s21, s31;
  logic [AngleBits-1:0]      t21, t31;
  logic signed [AngleBits:0] c12, c13;
  logic signed [SumBits-1:0] diff_d, sum_d, diff_q, sum_q;

  // round-to-nearest rescale to AB bits, kept mod 2^AB
  assign s21 = {p21_q, {(AngleBits + 1){1'b0}}} + InRound;
  assign s31 = {p31_q, {(AngleBits + 1){1'b0}}} + InRound;
  assign t21 = AngleBits'(0) - s21[ScaleBits-1:PHASE_BITS+1] - bias21_i;
  assign t31 = AngleBits'(0) - s31[ScaleBits-1:PHASE_BITS+1] - bias31_i;
  // exactly half a turn stays positive
  assign c12 = {t21[AngleBits-1] & (|t21[AngleBits-2:0]), t21};
  assign c13 = {t31[AngleBits-1] & (|t31[AngleBits-2:0]), t31};
  assign diff_d = SumBits'(c13) - SumBits'(c12);
  assign sum_d  = SumBits'(c12) + SumBits'(c13);

  // stage 2: y = sqrt3 * diff, x = sum at the same scale
  logic signed [ProdBits-1:0] y2_d, y2_q;
  logic signed [XBits-1:0]    x2_d, x2_q;
  logic                       z2_d, z2_q;

  assign y2_d = ProdBits'(diff_q) * ProdBits'(SQRT3_Q30);
  assign x2_d = XBits'(sum_q) <<< SQRT3_FRAC_BITS;
  assign z2_d = (diff_q == '0) && (sum_q == '0);

  // stage 3: left half-plane turned by a quarter
  logic signed [CordicBits-1:0] xe, ye, x3_d, y3_d, x3_q, y3_q;
  logic [AngleBits-1:0]         a3_d, a3_q;
  logic                         z3_q;

  assign xe = CordicBits'(x2_q);
  assign ye = CordicBits'(y2_q);

  always_comb begin
    x3_d = xe;
    y3_d = ye;
    a3_d = '0;
    if (xe[CordicBits-1]) begin
      if (!ye[CordicBits-1]) begin
        x3_d = ye;
        y3_d = -xe;
        a3_d = Quarter;
      end else begin
        x3_d = -ye;
        y3_d = xe;
        a3_d = AngleBits'(0) - Quarter;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r0) v0_q <= in_valid_i;
      if (r1) v1_q <= v0_q;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r0 && in_valid_i) begin
      p21_q <= phase21_i;
      p31_q <= phase31_i;
    end
    if (r1 && v0_q) begin
      diff_q <= diff_d;
      sum_q  <= sum_d;
    end
    if (r2 && v1_q) begin
      y2_q <= y2_d;
      x2_q <= x2_d;
      z2_q <= z2_d;
    end
    if (r3 && v2_q) begin
      x3_q <= x3_d;
      y3_q <= y3_d;
      a3_q <= a3_d;
      z3_q <= z2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign x_o         = x3_q;
  assign y_o         = y3_q;
  assign z_o         = a3_q;
  assign zero_o      = z3_q;

endmodule

// ===== rtl/core/pdoa_aoa_cordic_stage.sv =====
// One registered CORDIC vectoring iteration with its own valid/ready stage.
// Uses pdoa_aoa_pkg for the arctangent table.
module pdoa_aoa_cordic_stage #(
  parameter int unsigned AngleBits  = pdoa_aoa_pkg::ANGLE_BITS,
  parameter int unsigned CordicBits = pdoa_aoa_pkg::ANGLE_BITS +
                                      pdoa_aoa_pkg::CORDIC_GUARD_BITS,
  parameter int unsigned Index      = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [CordicBits-1:0]  x_i,
  input  logic signed [CordicBits-1:0]  y_i,
  input  logic [AngleBits-1:0]          z_i,
  input  logic                          zero_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [CordicBits-1:0]  x_o,
  output logic signed [CordicBits-1:0]  y_o,
  output logic [AngleBits-1:0]          z_o,
  output logic                          zero_o
);
  import pdoa_aoa_pkg::*;

  localparam logic [AngleBits-1:0] Step = AngleBits'(atan_step(5'(Index), AngleBits));

  logic                         valid_q;
  logic signed [CordicBits-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic [AngleBits-1:0]         z_d, z_q;
  logic                         zero_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign xs = x_i >>> Index;
  assign ys = y_i >>> Index;

  // drive y toward zero
  always_comb begin
    if (!y_i[CordicBits-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Step;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      zero_q <= zero_i;
    end
  end

  assign out_valid_o = valid_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign z_o         = z_q;
  assign zero_o      = zero_q;

endmodule

// ===== rtl/core/pdoa_aoa_checker.sv =====
// Port-level checks for the angle-of-arrival unit, bound to its top level.
// Uses pdoa_aoa_pkg for the register index codes.
module pdoa_aoa_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tready,
  input  logic [pdoa_aoa_pkg::OUT_BITS-1:0]       m_axis_tdata,
  input  logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_o,
  input  logic [pdoa_aoa_pkg::CFG_INDEX_BITS-1:0] cfg_index_i
);
  import pdoa_aoa_pkg::*;

  logic cfg_known_wr;
  assign cfg_known_wr = cfg_valid_i && cfg_ready_o &&
                        ((cfg_index_i == CFG_BIAS_21) || (cfg_index_i == CFG_BIAS_31) ||
                         (cfg_index_i == CFG_OFFSET));

  // a known write starts a conversion that holds both ports off
  a_cfg_busy_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_known_wr |=> (!cfg_ready_o && !s_axis_tready))
    else $error("conversion did not start after config write");

  // no input beat while the converted values are changing
  a_no_input_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_ready_o |-> !s_axis_tready)
    else $error("input ready during config conversion");

  // the config port only goes busy because of a write beat
  a_busy_only_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cfg_ready_o) |-> $past(cfg_valid_i))
    else $error("config port went busy without a write");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output beat changed while stalled");

endmodule

bind pdoa_to_angle_of_arrival_unit pdoa_aoa_checker u_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for pdoa_to_angle_of_arrival_unit: random and corner-case phase pairs
// under several bias/offset settings, results checked against an in-bench predictor.
// Depends on pdoa_aoa_pkg and the unit's RTL only.
module testbench;
  import pdoa_aoa_pkg::*;

  localparam int unsigned ANGLE_W     = pdoa_aoa_pkg::ANGLE_BITS;
  localparam int unsigned STAGES      = pdoa_aoa_pkg::CORDIC_STAGES;
  localparam longint      HALF_COUNTS = pdoa_aoa_pkg::COUNTS_PER_HALF_TURN;
  localparam longint      TURN        = 64'sd1 << ANGLE_W;
  localparam longint      HALF_TURN   = 64'sd1 << (ANGLE_W - 1);
  localparam longint      ROOT3_Q30   = 64'sd1859775393;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;  // no register here
  localparam int          STALL_LIMIT = 1000;
  localparam int          PHASES      = 8;
  localparam int          RAND_ITEMS  = 185;

  // Predicts the arrival angle of each accepted measurement and checks results in order.
  class angle_scoreboard;
    logic [15:0] bias21, bias31;
    logic [8:0]  offset_deg;
    logic [15:0] pending_angles[$];
    int unsigned mismatches;

    function new();
      bias21 = '0;
      bias31 = '0;
      offset_deg = '0;
      mismatches = 0;
    endfunction

    static function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d < 0) q--;
      return q;
    endfunction

    // fold into (-half turn, half turn]
    static function longint fold_turn(longint v);
      longint r;
      r = v & (TURN - 1);
      if (r > HALF_TURN) r -= TURN;
      return r;
    endfunction

    static function longint bias_to_turn(logic [15:0] b);
      return floor_div(longint'($signed(b)) * TURN + HALF_COUNTS, 2 * HALF_COUNTS);
    endfunction

    // vectoring CORDIC, binary-angle output
    static function longint vector_angle(longint y, longint x);
      longint atan_tbl[24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};
      longint z, t, step, xs, ys;
      if (x == 0 && y == 0) return 0;
      z = 0;
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y;
          y = -t;
          z = TURN / 4;
        end else begin
          x = -y;
          y = t;
          z = -(TURN / 4);
        end
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
        step = (atan_tbl[i] + (64'sd1 << (31 - ANGLE_W))) >> (32 - ANGLE_W);
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z += step;
        end else begin
          x = x - ys;
          y = y + xs;
          z -= step;
        end
      end
      return z;
    endfunction

    function logic [15:0] predict_angle(logic [15:0] ph21, logic [15:0] ph31);
      longint p21, p31, c12, c13, y, x, z, offa, r, res;
      p21 = floor_div(longint'($signed(ph21)) * TURN * 2 + 65536, 131072);
      p31 = floor_div(longint'($signed(ph31)) * TURN * 2 + 65536, 131072);
      c12 = fold_turn(-p21 - bias_to_turn(bias21));
      c13 = fold_turn(-p31 - bias_to_turn(bias31));
      y = (c13 - c12) * ROOT3_Q30;
      x = (c12 + c13) * (64'sd1 << 30);
      z = vector_angle(y, x);
      offa = floor_div(longint'($signed(offset_deg)) * TURN * 2 + 360, 720);
      r = (z + offa) & (TURN - 1);
      res = ((r << 17) + (64'sd1 << ANGLE_W)) >> (ANGLE_W + 1);
      return res[15:0];
    endfunction

    // phase that cancels a bias, so the corrected phase comes out zero
    function logic [15:0] null_phase(logic [15:0] b);
      longint p;
      p = floor_div(-bias_to_turn(b) * 65536, TURN);
      return p[15:0];
    endfunction

    function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_BIAS_21: bias21 = data;
        CFG_BIAS_31: bias31 = data;
        CFG_OFFSET:  offset_deg = data[8:0];
        default: ;
      endcase
    endfunction

    function void note_measurement(logic [15:0] ph21, logic [15:0] ph31);
      pending_angles.push_back(predict_angle(ph21, ph31));
    endfunction

    function void check_angle(logic [15:0] actual);
      logic [15:0] want;
      if (pending_angles.size() == 0) begin
        $display("%0t: unexpected angle beat, expected none, actual %h", $time, actual);
        mismatches++;
      end else begin
        want = pending_angles.pop_front();
        if (actual !== want) begin
          $display("%0t: arrival_angle mismatch, expected %h, actual %h", $time, want, actual);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return pending_angles.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_axis_tdata = '0;   // [15:0] phase_ant2_ant1, [31:16] phase_ant3_ant1
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] m_axis_tdata;        // [15:0] arrival_angle
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i = '0;

  angle_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cycles = 0;

  always #10 clk_i = ~clk_i;

  pdoa_to_angle_of_arrival_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Result side: check every accepted beat, then pick next cycle's tready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_angle(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog: too long without any beat on any channel means a hang.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // One measurement beat. tvalid stays high into the next call unless a gap is rolled,
  // so it never gets two assignments in one step.
  task automatic send_measurement(input logic [15:0] ph21, input logic [15:0] ph31);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tdata  <= {ph31, ph21};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_measurement(ph21, ph31);
  endtask

  // Drop tvalid and wait until every predicted angle has come back.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
  endtask

  // Back-to-back register writes; pipeline must be empty.
  task automatic program_regs(input logic [15:0] b21, input logic [15:0] b31,
                              input int off, input bit poke_spare);
    logic [CFG_INDEX_BITS-1:0] idx_list[4];
    logic [15:0]               val_list[4];
    int n;
    n = 0;
    if (poke_spare) begin
      idx_list[n] = CFG_SPARE;
      val_list[n] = 16'($urandom);
      n++;
    end
    idx_list[n] = CFG_BIAS_21; val_list[n] = b21;      n++;
    idx_list[n] = CFG_BIAS_31; val_list[n] = b31;      n++;
    idx_list[n] = CFG_OFFSET;  val_list[n] = 16'(off); n++;
    for (int k = 0; k < n; k++) begin
      cfg_index_i <= idx_list[k];
      cfg_data_i  <= val_list[k];
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_register(idx_list[k], val_list[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] corner_phase();
    case ($urandom_range(0, 6))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h0001;
      4: return 16'hffff;
      5: return 16'h4000;
      default: return 16'hc000;
    endcase
  endfunction

  // Mostly random pairs, plus pairs aimed at y = 0, x = 0 and the zero vector
  // under the current biases.
  task automatic send_random_measurement();
    logic [15:0] k21, k31, p21, p31;
    k21 = sb.null_phase(sb.bias21);
    k31 = sb.null_phase(sb.bias31);
    p21 = 16'($urandom);
    p31 = 16'($urandom);
    case ($urandom_range(0, 9))
      5: p31 = corner_phase();
      6: p31 = k31 + k21 - p21;                   // sum of corrected phases is zero
      7: begin                                    // zero vector, or next to it
        p21 = k21 + 16'($urandom_range(0, 2)) - 16'd1;
        p31 = k31 + 16'($urandom_range(0, 2)) - 16'd1;
      end
      8: begin
        p21 = corner_phase();
        p31 = corner_phase();
      end
      9: p31 = p21 - k21 + k31;                   // equal corrected phases
      default: ;
    endcase
    send_measurement(p21, p31);
  endtask

  initial begin
    logic [15:0] b21, b31;
    int off;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < PHASES; ph++) begin
      // idle pattern: receiver-heavy gaps, then sender-heavy, then none
      if (ph < 3) begin
        tx_idle_pct = 30;
        rx_idle_pct = 50;
      end else if (ph < 6) begin
        tx_idle_pct = 50;
        rx_idle_pct = 30;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      b21 = 16'($urandom);
      b31 = 16'($urandom);
      off = $urandom_range(0, 360) - 180;
      case (ph)
        0: begin b21 = 16'h0000; b31 = 16'h0000; off = 0;    end
        1: begin b21 = 16'h7fff; b31 = 16'h8000; off = 180;  end
        2: begin b21 = 16'h8000; b31 = 16'h7fff; off = -180; end
        3: off = 255;                              // beyond +-180, wraps
        4: begin b21 = 16'h1000; b31 = 16'hf000; off = -256; end
        6: begin b21 = 16'h0001; b31 = 16'hffff; off = 90;   end
        default: ;
      endcase
      drain_pipeline();
      program_regs(b21, b31, off, (ph == 1 || ph == 5));

      if (ph == 0) begin
        // zero biases: corner cases of the phase path
        send_measurement(16'h0000, 16'h0000);   // zero vector
        send_measurement(16'h7fff, 16'h7fff);
        send_measurement(16'h8000, 16'h8000);   // both exactly pi, stays +pi
        send_measurement(16'h8000, 16'h0000);
        send_measurement(16'h0000, 16'h8000);
        send_measurement(16'h7fff, 16'h8000);
        send_measurement(16'h8000, 16'h7fff);
        send_measurement(16'h4000, 16'h4000);   // x < 0, y = 0: +180
        send_measurement(16'h4000, 16'hc000);   // x = 0, y > 0
        send_measurement(16'hc000, 16'h4000);   // x = 0, y < 0
        send_measurement(16'd20000, 16'd10000); // left half, y > 0
        send_measurement(16'd10000, 16'd20000); // left half, y < 0
        send_measurement(16'h0001, 16'h0000);
        send_measurement(16'h0000, 16'h0001);
        send_measurement(16'hffff, 16'h0000);
        send_measurement(16'h0000, 16'hffff);
        send_measurement(16'h5555, 16'haaaa);
        send_measurement(16'haaaa, 16'h5555);
      end
      for (int n = 0; n < RAND_ITEMS; n++) send_random_measurement();
    end

    drain_pipeline();
    repeat (STAGES + 10) @(posedge clk_i);  // catch any stray extra beats
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
